// ===== hw/rtl/pfc_pkg.sv =====
// Playfair cipher package: command and status codes, FSM and action types,
// controller/datapath interface structs, letter and grid helper functions.
// No dependencies.
`default_nettype none

package pfc_pkg;

  // input commands
  localparam logic [2:0] CMD_CLEAR   = 3'd0;
  localparam logic [2:0] CMD_KEY     = 3'd1;
  localparam logic [2:0] CMD_FINISH  = 3'd2;
  localparam logic [2:0] CMD_ENCRYPT = 3'd3;
  localparam logic [2:0] CMD_DECRYPT = 3'd4;

  // result status
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_IN_SQ  = 2'd1;
  localparam logic [1:0] ST_NOT_READY  = 2'd2;

  // letter codes 0..25, plus a marker for anything outside the square
  localparam logic [4:0] NOT_IN_SQUARE = 5'd31;
  localparam logic [4:0] CODE_I        = 5'd8;
  localparam logic [4:0] CODE_J        = 5'd9;
  localparam logic [4:0] CODE_X        = 5'd23;
  localparam logic [4:0] CODE_Z        = 5'd25;
  localparam logic [4:0] NUM_LETTERS   = 5'd26;
  localparam logic [4:0] NUM_CELLS     = 5'd25;

  localparam logic [7:0] ASCII_A       = 8'h41;
  localparam logic [7:0] ASCII_Z       = 8'h5A;
  localparam logic [7:0] ASCII_LOW_A   = 8'h61;
  localparam logic [7:0] ASCII_LOW_Z   = 8'h7A;
  localparam logic [7:0] ASCII_CASE    = 8'h20;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FILL = 5'b00010,
    S_POS  = 5'b00100,
    S_SQR  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CLEAR,
    ACT_KEY,
    ACT_FILL,
    ACT_HOLD,
    ACT_PAIR,
    ACT_EMIT
  } action_t;

  typedef struct packed {
    logic accept;     // input transfer this cycle
    logic fill_step;  // place next alphabet letter
    logic look;       // read letter positions
    logic sq_rd;      // read square cells
    logic load;       // load output register
  } ctl_cmd_t;

  typedef struct packed {
    action_t action;  // what the offered item calls for
    logic    fill_done;
    logic    out_free;
  } dp_sts_t;

  function automatic logic [4:0] letter_code(input logic [7:0] c);
    logic [7:0] u;
    logic [4:0] k;
    u = (c >= ASCII_LOW_A && c <= ASCII_LOW_Z) ? c - ASCII_CASE : c;
    k = 5'(u - ASCII_A);
    if (k == CODE_J) k = CODE_I;
    if (u < ASCII_A || u > ASCII_Z) k = NOT_IN_SQUARE;
    return k;
  endfunction

  function automatic logic [2:0] pos_row(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20)      r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  function automatic logic [2:0] pos_col(input logic [4:0] p);
    logic [4:0] base;
    base = {2'b00, pos_row(p)} * 5'd5;
    return 3'(p - base);
  endfunction

  function automatic logic [2:0] add_mod5(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 4'd5) s = s - 4'd5;
    return 3'(s);
  endfunction

  function automatic logic [4:0] cell_addr(input logic [2:0] r, input logic [2:0] c);
    return ({2'b00, r} * 5'd5) + {2'b00, c};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pfc_ctrl.sv =====
// Playfair controller: one-hot FSM sequencing accept, alphabet fill,
// position lookup, square lookup and output load. Depends on pfc_pkg.
`default_nettype none

module pfc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire pfc_pkg::dp_sts_t sts,
  output pfc_pkg::ctl_cmd_t     cmd
);

  pfc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= pfc_pkg::S_IDLE;
    else     state <= state_next;
  end

  assign in_stall = (state != pfc_pkg::S_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    case (state)
      pfc_pkg::S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          case (sts.action)
            pfc_pkg::ACT_FILL: state_next = pfc_pkg::S_FILL;
            pfc_pkg::ACT_PAIR: state_next = pfc_pkg::S_POS;
            pfc_pkg::ACT_EMIT: state_next = pfc_pkg::S_EMIT;
            default:           state_next = pfc_pkg::S_IDLE;
          endcase
        end
      end
      pfc_pkg::S_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_done) state_next = pfc_pkg::S_IDLE;
      end
      pfc_pkg::S_POS: begin
        cmd.look   = 1'b1;
        state_next = pfc_pkg::S_SQR;
      end
      pfc_pkg::S_SQR: begin
        cmd.sq_rd  = 1'b1;
        state_next = pfc_pkg::S_EMIT;
      end
      pfc_pkg::S_EMIT: begin
        cmd.load = sts.out_free;
        if (sts.out_free) state_next = pfc_pkg::S_IDLE;
      end
      default: state_next = pfc_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pfc_datapath.sv =====
// Playfair datapath: key square and letter position memories, key and
// pairing state, cipher arithmetic and output register. Depends on pfc_pkg.
`default_nettype none

module pfc_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [2:0]        cmd,
  input  wire logic [7:0]        char_in,
  input  wire logic              last,
  input  wire pfc_pkg::ctl_cmd_t ctl,
  output pfc_pkg::dp_sts_t       sts,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_first,
  output logic [7:0]             out_second,
  output logic [1:0]             status
);

  logic [4:0] sq_mem  [25];
  logic [4:0] pos_mem [26];
  logic       letter_used [26];

  logic [4:0] fill_count;
  logic       square_ready;
  logic [4:0] pending_letter;
  logic       pending_valid;
  logic [4:0] fill_letter;

  logic [4:0] a_code, b_code;
  logic       enc;
  logic [1:0] err;
  logic [4:0] pos_a, pos_b;
  logic [4:0] sq_a, sq_b;

  // grid rule on registered positions
  logic [2:0] ra, ca, rb, cb, shift;
  logic [4:0] addr_a, addr_b;

  // decode of the offered item
  logic       is_msg, is_enc;
  logic [4:0] code;
  logic [4:0] pa_sel, pb_sel, pb_fix;
  logic       clr_pending;
  logic [1:0] err_sel;
  pfc_pkg::action_t act;

  always_comb begin
    is_enc      = (cmd == pfc_pkg::CMD_ENCRYPT);
    is_msg      = is_enc || (cmd == pfc_pkg::CMD_DECRYPT);
    code        = pfc_pkg::letter_code(char_in);
    pa_sel      = code;
    pb_sel      = pfc_pkg::CODE_X;
    clr_pending = 1'b0;
    err_sel     = pfc_pkg::ST_OK;
    act         = pfc_pkg::ACT_NONE;
    case (cmd)
      pfc_pkg::CMD_CLEAR:  act = pfc_pkg::ACT_CLEAR;
      pfc_pkg::CMD_KEY:    act = square_ready ? pfc_pkg::ACT_NONE : pfc_pkg::ACT_KEY;
      pfc_pkg::CMD_FINISH: act = square_ready ? pfc_pkg::ACT_NONE : pfc_pkg::ACT_FILL;
      default:             act = pfc_pkg::ACT_NONE;
    endcase
    if (is_msg) begin
      if (!square_ready) begin
        act     = pfc_pkg::ACT_EMIT;
        err_sel = pfc_pkg::ST_NOT_READY;
      end else if (is_enc && code == pfc_pkg::NOT_IN_SQUARE) begin
        // non-letter in plaintext: only flushes a pending letter on last
        if (last && pending_valid) begin
          act         = pfc_pkg::ACT_PAIR;
          pa_sel      = pending_letter;
          clr_pending = 1'b1;
        end
      end else if (pending_valid) begin
        act         = pfc_pkg::ACT_PAIR;
        pa_sel      = pending_letter;
        pb_sel      = code;
        clr_pending = 1'b1;
      end else if (last) begin
        act = pfc_pkg::ACT_PAIR;
      end else begin
        act = pfc_pkg::ACT_HOLD;
      end
      if (act == pfc_pkg::ACT_PAIR &&
          (pa_sel >= pfc_pkg::NUM_LETTERS || pb_sel >= pfc_pkg::NUM_LETTERS)) begin
        act     = pfc_pkg::ACT_EMIT;
        err_sel = pfc_pkg::ST_NOT_IN_SQ;
      end
    end
    pb_fix = (is_enc && pa_sel == pb_sel) ? pfc_pkg::CODE_X : pb_sel;
  end

  assign sts.action    = act;
  assign sts.fill_done = (fill_letter == pfc_pkg::CODE_Z);
  assign sts.out_free  = !out_valid || !out_stall;

  // shared placement port for key letters and alphabet fill
  logic [4:0] wr_code;
  logic       used_hit, wr_en;

  always_comb begin
    wr_code  = ctl.fill_step ? fill_letter : code;
    used_hit = (wr_code < pfc_pkg::NUM_LETTERS) ? letter_used[wr_code] : 1'b1;
    wr_en    = ((ctl.accept && act == pfc_pkg::ACT_KEY) ||
                (ctl.fill_step && fill_letter != pfc_pkg::CODE_J)) &&
               !used_hit && (fill_count < pfc_pkg::NUM_CELLS);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sq_mem[fill_count]  <= wr_code;
      pos_mem[wr_code]    <= fill_count;
    end
    if (ctl.look) begin
      pos_a <= pos_mem[a_code];
      pos_b <= pos_mem[b_code];
    end
    if (ctl.sq_rd) begin
      sq_a <= sq_mem[addr_a];
      sq_b <= sq_mem[addr_b];
    end
  end

  // key state
  always_ff @(posedge clk) begin
    if (rst || (ctl.accept && act == pfc_pkg::ACT_CLEAR)) begin
      for (int i = 0; i < 26; i++) letter_used[i] <= 1'b0;
      fill_count     <= '0;
      square_ready   <= 1'b0;
      pending_letter <= '0;
      pending_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        letter_used[wr_code] <= 1'b1;
        fill_count           <= fill_count + 5'd1;
      end
      if (ctl.fill_step && sts.fill_done) square_ready <= 1'b1;
      if (ctl.accept && act == pfc_pkg::ACT_HOLD) begin
        pending_letter <= code;
        pending_valid  <= 1'b1;
      end else if (ctl.accept && clr_pending) begin
        pending_letter <= '0;
        pending_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) fill_letter <= '0;
    else if (ctl.fill_step) fill_letter <= fill_letter + 5'd1;
  end

  // pair registers
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      a_code <= pa_sel;
      b_code <= pb_fix;
      enc    <= is_enc;
      err    <= err_sel;
    end
  end

  always_comb begin
    ra    = pfc_pkg::pos_row(pos_a);
    ca    = pfc_pkg::pos_col(pos_a);
    rb    = pfc_pkg::pos_row(pos_b);
    cb    = pfc_pkg::pos_col(pos_b);
    shift = enc ? 3'd1 : 3'd4;
    if (ra == rb) begin
      addr_a = pfc_pkg::cell_addr(ra, pfc_pkg::add_mod5(ca, shift));
      addr_b = pfc_pkg::cell_addr(rb, pfc_pkg::add_mod5(cb, shift));
    end else if (ca == cb) begin
      addr_a = pfc_pkg::cell_addr(pfc_pkg::add_mod5(ra, shift), ca);
      addr_b = pfc_pkg::cell_addr(pfc_pkg::add_mod5(rb, shift), cb);
    end else begin
      addr_a = pfc_pkg::cell_addr(ra, cb);
      addr_b = pfc_pkg::cell_addr(rb, ca);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ctl.load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      status     <= err;
      out_first  <= (err == pfc_pkg::ST_OK) ? pfc_pkg::ASCII_A + {3'b000, sq_a} : 8'd0;
      out_second <= (err == pfc_pkg::ST_OK) ? pfc_pkg::ASCII_A + {3'b000, sq_b} : 8'd0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/playfair_cipher.sv =====
// Playfair cipher top level: joins the controller FSM and the datapath.
// Depends on pfc_pkg, pfc_ctrl and pfc_datapath.
//
// Playfair engine with a 5x5 key square, I and J sharing a cell. Send
// cmd 0 to clear the key, cmd 1 with key characters (non-letters dropped,
// lowercase folded, repeats ignored), then cmd 2 to finish the square;
// finish fills the remaining cells with unused letters A..Z in order, one
// alphabet letter per cycle through the single write port of the square
// memory. Message characters then go in with cmd 3 (encrypt) or cmd 4
// (decrypt), one per transfer; every second character, or a character
// flagged with last, produces one output transfer with the enciphered pair
// in out_first/out_second. A pair goes from input transfer to output
// register through accept, letter position memory read, square memory
// read and output load, which waits while the output register holds a
// stalled result; a character that only waits for its partner takes the
// accept alone. The next input is taken as soon as the output register is
// loaded, even if that result is still stalled. status 1 flags a pair with
// a character outside the square, status 2 a message sent before the square
// was finished; both give zero letters. Key commands produce no output.
`default_nettype none

module playfair_cipher (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] cmd,
  input  wire logic [7:0] char_in,
  input  wire logic       last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_first,
  output logic [7:0]      out_second,
  output logic [1:0]      status
);

  pfc_pkg::ctl_cmd_t ctl_cmd;
  pfc_pkg::dp_sts_t  dp_sts;

  // sequencing: one item in flight, phases driven by the FSM
  pfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (dp_sts),
    .cmd      (ctl_cmd)
  );

  // storage, key state, grid rule and output register
  pfc_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .char_in    (char_in),
    .last       (last),
    .ctl        (ctl_cmd),
    .sts        (dp_sts),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_first  (out_first),
    .out_second (out_second),
    .status     (status)
  );

`ifndef SYNTHESIS
  // the FSM runs one phase at a time
  a_one_phase: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl_cmd.accept, ctl_cmd.fill_step, ctl_cmd.look, ctl_cmd.sq_rd, ctl_cmd.load}))
    else $error("more than one controller phase active");

  // position read is always followed by the square read
  a_look_cell: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.look |=> ctl_cmd.sq_rd)
    else $error("square read did not follow position read");

  // no input transfer while a pair is in the lookup pipe
  a_cell_stall: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.sq_rd |=> in_stall)
    else $error("input taken during pair lookup");

  // a load always presents a result
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.load |=> out_valid)
    else $error("output load lost");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_playfair_cipher.sv =====
// Self-checking testbench for the playfair_cipher engine: key loading, square fill,
// encrypt/decrypt pairing, error status and output backpressure.
// Depends on pfc_pkg (command/status codes, ASCII constants) and playfair_cipher.

module tb_playfair_cipher;
  import pfc_pkg::*;

  // cmd values the block ignores
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

  // Cycle budget. Worst case per item is a long input gap, a long output
  // stall, the pair latency and the square fill, for about 700 items; this
  // is several times that.
  localparam int LIMIT_CYCLES  = 400000;
  localparam int RANDOM_ITEMS  = 560;
  localparam int DRAIN_CYCLES  = 40;
  localparam int MAX_PRINTED   = 40;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic [1:0] st;
  } pair_res_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [2:0] cmd       = CMD_CLEAR;
  logic [7:0] char_in   = 8'h00;
  logic       last      = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_first;
  logic [7:0] out_second;
  logic [1:0] status;

  playfair_cipher uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .char_in    (char_in),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_first  (out_first),
    .out_second (out_second),
    .status     (status)
  );

  // 8-unit period: 4 low, 4 high
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // Predictor state: our own copy of the key square and pairing state.
  // ------------------------------------------------------------------
  logic [4:0] key_sq  [25];   // cell -> letter code
  logic [4:0] key_pos [26];   // letter code -> cell
  bit         key_used[26];
  int         key_fill;
  bit         key_ready;
  logic [4:0] held_code;      // first half of an open pair
  bit         held_valid;

  pair_res_t expected_pairs[$];  // predicted output transfers, oldest first

  int  n_items;
  int  n_results;
  int  n_bad_sq;
  int  n_not_ready;
  int  err_cnt;
  int  cycles;
  int  hold_left;   // pressure test: cycles the receiver must hold off
  bit  quiet;       // no new random gaps or stall runs while set

  // Uppercase fold, non-letters to the off-square marker, J shares I.
  function automatic logic [4:0] char_to_code(input logic [7:0] c);
    logic [7:0] u;
    logic [4:0] k;
    u = c;
    if (c >= ASCII_LOW_A && c <= ASCII_LOW_Z) u = c - ASCII_CASE;
    k = 5'(u - ASCII_A);
    if (k == CODE_J) k = CODE_I;
    if (u < ASCII_A || u > ASCII_Z) k = NOT_IN_SQUARE;
    return k;
  endfunction

  task automatic clear_key();
    for (int k = 0; k < 26; k++) begin
      key_used[k] = 1'b0;
      key_pos[k]  = 5'd0;
    end
    for (int k = 0; k < 25; k++) key_sq[k] = 5'd0;
    key_fill   = 0;
    key_ready  = 1'b0;
    held_code  = 5'd0;
    held_valid = 1'b0;
  endtask

  task automatic place_code(input logic [4:0] code);
    if (code < NUM_LETTERS) begin
      if (!key_used[code] && key_fill < 25) begin
        key_sq[key_fill] = code;
        key_pos[code]    = 5'(key_fill);
        key_used[code]   = 1'b1;
        key_fill++;
      end
    end
  endtask

  // Row rule, column rule, rectangle rule; shift 1 to encrypt, 4 to decrypt.
  function automatic pair_res_t cipher_pair(input logic [4:0] a, input logic [4:0] b_in,
                                            input bit enc);
    pair_res_t r;
    logic [4:0] b;
    int pa, pb, ra, ca, rb, cb, sh, t;
    r = '{8'h00, 8'h00, ST_NOT_IN_SQ};
    if (a < NUM_LETTERS && b_in < NUM_LETTERS) begin
      b  = (enc && a == b_in) ? CODE_X : b_in;
      pa = key_pos[a];
      pb = key_pos[b];
      ra = pa / 5;  ca = pa % 5;
      rb = pb / 5;  cb = pb % 5;
      sh = enc ? 1 : 4;
      if (ra == rb) begin
        ca = (ca + sh) % 5;
        cb = (cb + sh) % 5;
      end else if (ca == cb) begin
        ra = (ra + sh) % 5;
        rb = (rb + sh) % 5;
      end else begin
        t  = ca;
        ca = cb;
        cb = t;
      end
      r.first  = ASCII_A + 8'(key_sq[ra * 5 + ca]);
      r.second = ASCII_A + 8'(key_sq[rb * 5 + cb]);
      r.st     = ST_OK;
    end
    return r;
  endfunction

  // Runs one accepted item through the predictor; queues any pair it yields.
  task automatic predict_cipher(input logic [2:0] c, input logic [7:0] ch, input logic lst);
    logic [4:0] code;
    bit enc;
    code = char_to_code(ch);
    enc  = (c == CMD_ENCRYPT);
    case (c)
      CMD_CLEAR: clear_key();
      CMD_KEY: begin
        if (!key_ready) place_code(code);
      end
      CMD_FINISH: begin
        if (!key_ready) begin
          for (int k = 0; k < 26; k++)
            if (5'(k) != CODE_J) place_code(5'(k));
          key_ready = 1'b1;
        end
      end
      CMD_ENCRYPT, CMD_DECRYPT: begin
        if (!key_ready) begin
          expected_pairs.push_back('{8'h00, 8'h00, ST_NOT_READY});
        end else if (enc && code == NOT_IN_SQUARE) begin
          // encrypt skips non-letters; last still flushes an open pair
          if (lst && held_valid) begin
            expected_pairs.push_back(cipher_pair(held_code, CODE_X, enc));
            held_valid = 1'b0;
            held_code  = 5'd0;
          end
        end else if (held_valid) begin
          expected_pairs.push_back(cipher_pair(held_code, code, enc));
          held_valid = 1'b0;
          held_code  = 5'd0;
        end else if (lst) begin
          expected_pairs.push_back(cipher_pair(code, CODE_X, enc));
        end else begin
          held_code  = code;
          held_valid = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // ------------------------------------------------------------------
  // Idle and stall lengths: mostly short, now and then long.
  // ------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_stall();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random stall runs, or a forced hold-off for the pressure test.
  int run_left    = 0;
  bit run_stalled = 1'b0;

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (run_left == 0) begin
        run_stalled = !quiet && ($urandom_range(0, 2) == 0);
        run_left    = run_stalled ? pick_stall() : $urandom_range(1, 12);
      end
      run_left = run_left - 1;
      out_stall <= run_stalled;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_pairs.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    if (err_cnt < MAX_PRINTED)
      $display("mismatch at cycle %0d, result %0d: %s expected 0x%0h got 0x%0h",
               cycles, n_results, what, exp_v, got_v);
    err_cnt++;
  endtask

  // Result checker. Outputs and out_stall are settled by the falling edge
  // and hold until the next rising edge, which is where the transfer lands.
  always @(negedge clk) begin : check_results
    pair_res_t exp_pair;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      n_results++;
      if (status == ST_NOT_IN_SQ) n_bad_sq++;
      if (status == ST_NOT_READY) n_not_ready++;
      if (expected_pairs.size() == 0) begin
        report_mismatch("unexpected result, status", 0, status);
      end else begin
        exp_pair = expected_pairs.pop_front();
        if (out_first !== exp_pair.first)
          report_mismatch("out_first", exp_pair.first, out_first);
        if (out_second !== exp_pair.second)
          report_mismatch("out_second", exp_pair.second, out_second);
        if (status !== exp_pair.st)
          report_mismatch("status", exp_pair.st, status);
      end
    end
  end

  // ------------------------------------------------------------------
  // Sender: one input transfer. Starts and returns at a rising edge.
  // in_stall is sampled at the falling edge, where it has settled.
  // ------------------------------------------------------------------
  task automatic send_char(input logic [2:0] c, input logic [7:0] ch, input logic lst);
    int gap;
    bit taken;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    char_in  <= ch;
    last     <= lst;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = (in_stall === 1'b0);
      @(posedge clk);
    end
    predict_cipher(c, ch, lst);
    n_items++;
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? ASCII_A : ASCII_LOW_A;
    return base + 8'($urandom_range(0, 25));
  endfunction

  // Message characters: mostly letters, some J/X, some arbitrary bytes.
  function automatic logic [7:0] rand_msg_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return rand_letter();
    if (r < 88) begin
      case ($urandom_range(0, 3))
        0:       return "J";
        1:       return "j";
        2:       return "X";
        default: return "x";
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Messages sent before any square exists must report not-ready.
  task automatic test_before_finish();
    send_char(CMD_ENCRYPT, "A", 1'b0);
    send_char(CMD_DECRYPT, "z", 1'b1);
  endtask

  // Short key with J, a duplicate, noise; then each pairing corner case.
  task automatic test_directed_pairs();
    send_char(CMD_KEY, "j", 1'b0);
    send_char(CMD_KEY, "!", 1'b1);       // non-letter key, last ignored
    send_char(CMD_KEY, "K", 1'b0);
    send_char(CMD_KEY, "i", 1'b0);       // same cell as J, dropped
    send_char(CMD_KEY, "Z", 1'b0);
    send_char(CMD_FINISH, 8'h00, 1'b0);
    send_char(CMD_FINISH, 8'hFF, 1'b1);  // second finish is a no-op
    send_char(CMD_KEY, "Q", 1'b0);       // key after finish ignored
    send_char(CMD_ENCRYPT, "x", 1'b0);   // doubled X stays X X
    send_char(CMD_ENCRYPT, "X", 1'b0);
    send_char(CMD_ENCRYPT, "L", 1'b0);
    send_char(CMD_ENCRYPT, " ", 1'b0);   // skipped on encrypt
    send_char(CMD_ENCRYPT, "l", 1'b0);   // doubled letter -> L X
    send_char(CMD_ENCRYPT, "a", 1'b1);   // lone last letter padded
    send_char(CMD_ENCRYPT, "B", 1'b0);
    send_char(CMD_ENCRYPT, 8'hFF, 1'b1); // non-letter last flushes B X
    send_char(CMD_ENCRYPT, 8'h00, 1'b1); // nothing open: no result
    send_char(CMD_ENCRYPT, "C", 1'b0);   // mixed: decrypt closes the pair
    send_char(CMD_DECRYPT, "d", 1'b0);
    send_char(CMD_DECRYPT, "#", 1'b0);   // off-square char in a pair
    send_char(CMD_DECRYPT, "M", 1'b0);
    send_char(CMD_UNUSED_FIRST, "A", 1'b0);
    send_char(CMD_UNUSED_LAST, 8'hFF, 1'b1);
    send_char(CMD_DECRYPT, "E", 1'b1);   // odd decrypt tail padded
    send_char(CMD_CLEAR, 8'h55, 1'b1);
    send_char(CMD_ENCRYPT, "Z", 1'b0);   // square gone again
  endtask

  // Receiver holds off for a long stretch while the sender keeps pushing,
  // so the output register fills and in_stall must rise.
  task automatic test_backpressure();
    quiet = 1'b1;
    send_char(CMD_CLEAR, 8'h00, 1'b0);
    for (int k = 0; k < 6; k++) send_char(CMD_KEY, rand_letter(), 1'b0);
    send_char(CMD_FINISH, 8'h00, 1'b0);
    hold_left = 120;
    for (int k = 0; k < 40; k++)
      send_char(k[0] ? CMD_DECRYPT : CMD_ENCRYPT, rand_letter(), 1'b0);
    quiet = 1'b0;
  endtask

  // Key / finish / message sessions with random content and some noise.
  task automatic test_random_sessions();
    int sent;
    int klen;
    int mlen;
    int mode;
    logic [2:0] mcmd;
    logic lst;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 9) != 0)
        send_char(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      klen = $urandom_range(0, 10);
      for (int k = 0; k < klen; k++) begin
        send_char(CMD_KEY,
                  ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : rand_letter(),
                  1'($urandom_range(0, 1)));
        sent++;
      end
      // now and then leave the square unfinished
      if ($urandom_range(0, 11) != 0)
        send_char(CMD_FINISH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      case ($urandom_range(0, 7))
        0: send_char(CMD_FINISH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        1: send_char(CMD_KEY, rand_letter(), 1'($urandom_range(0, 1)));
        2: send_char(3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        default: ;
      endcase
      mode = $urandom_range(0, 3);
      mlen = $urandom_range(1, 30);
      for (int m = 0; m < mlen; m++) begin
        case (mode)
          0, 1:    mcmd = CMD_ENCRYPT;
          2:       mcmd = CMD_DECRYPT;
          default: mcmd = $urandom_range(0, 1) ? CMD_ENCRYPT : CMD_DECRYPT;
        endcase
        if (m == mlen - 1) lst = ($urandom_range(0, 3) != 0);
        else               lst = ($urandom_range(0, 19) == 0);
        send_char(mcmd, rand_msg_char(), lst);
        sent++;
      end
    end
    quiet = 1'b0;
  endtask

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------
  initial begin
    n_items     = 0;
    n_results   = 0;
    n_bad_sq    = 0;
    n_not_ready = 0;
    err_cnt     = 0;
    cycles      = 0;
    hold_left   = 0;
    quiet       = 1'b0;
    clear_key();

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_before_finish();
    test_directed_pairs();
    test_backpressure();
    test_random_sessions();
    in_valid <= 1'b0;

    // drain, then give any stray result time to show up
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input transfers and %0d output transfers in %0d cycles",
             n_items, n_results, cycles);
    $display("  %0d pairs flagged off-square, %0d sent before the square was ready",
             n_bad_sq, n_not_ready);
    if (err_cnt == 0 && expected_pairs.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
